/* sv/stst_pkg.sv */
// Shared constants, codes and control types of the soft timer slot table.
package stst_pkg;

  localparam int SLOT_COUNT     = 16;
  localparam int TICK_PERIOD_MS = 5;
  localparam int TICK_BITS      = 32;
  localparam int MAX_RESULTS    = 16;

  localparam int HANDLE_W = 8;
  localparam int DUR_W    = 18;
  localparam int IDX_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int RES_W    = $clog2(MAX_RESULTS + 1);

  // Exact division of a DUR_W-bit value by the tick period through one
  // multiplication by a rounded-up reciprocal and a right shift.
  localparam int DIV_L   = $clog2(TICK_PERIOD_MS);
  localparam int DIV_SH  = DUR_W + DIV_L;
  localparam int DIV_M_W = DUR_W + 1;
  localparam int PROD_W  = DUR_W + DIV_M_W;
  localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'((64'd1 << DIV_SH) / TICK_PERIOD_MS + 1);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SERVICE = 2'd1,
    OP_START   = 2'd2,
    OP_STOP    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_REJECTED = 3'd0,
    ST_REARMED  = 3'd1,
    ST_ADDED    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_EXPIRED  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ADD,
    S_RESULT,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic    load_item;
    logic    inc_now;
    logic    load_dl;
    logic    scan_clr;
    logic    scan_inc;
    logic    note_free;
    logic    wr_rearm;
    logic    wr_add;
    logic    wr_remove;
    logic    wr_expire;
    logic    set_st;
    status_e st;
    logic    push_res;
    logic    push_pend;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    dur_zero;
    logic    full;
    logic    empty;
    logic    cur_valid;
    logic    hit;
    logic    due;
    logic    idx_last;
    logic    free_found;
    logic    pend;
    logic    out_space;
    logic    cap;
  } dp_stat_t;

endpackage

/* sv/stst_in_if.sv */
// Input channel of the soft timer slot table: one command per transfer.
interface stst_in_if;
  import stst_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [HANDLE_W-1:0] handle;
  logic [DUR_W-1:0]    duration_ms;

  modport source (output valid, output opcode, output handle, output duration_ms,
                  input ready);
  modport sink   (input valid, input opcode, input handle, input duration_ms,
                  output ready);
endinterface

/* sv/stst_out_if.sv */
// Output channel of the soft timer slot table: one result per transfer.
interface stst_out_if;
  import stst_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [HANDLE_W-1:0] out_handle;
  logic                last;

  modport source (output valid, output status, output out_handle, output last,
                  input ready);
  modport sink   (input valid, input status, input out_handle, input last,
                  output ready);
endinterface

/* sv/stst_dp.sv */
// Datapath of the soft timer slot table: slot storage, counters and result register.
module stst_dp import stst_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          opcode_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [DUR_W-1:0]    duration_ms_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_stat_t            stat_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [2:0]          status_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic                last_o
);

  logic                slot_valid_q  [SLOT_COUNT];
  logic [HANDLE_W-1:0] slot_handle_q [SLOT_COUNT];
  logic [TICK_BITS-1:0] slot_dl_q    [SLOT_COUNT];

  logic [CNT_W-1:0]     active_q;
  logic [TICK_BITS-1:0] now_q;
  opcode_e              op_q;
  logic [HANDLE_W-1:0]  hdl_q;
  logic                 dur_zero_q;
  logic [PROD_W-1:0]    prod_q;
  logic [TICK_BITS-1:0] dl_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 free_found_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic                 pend_q;
  logic [HANDLE_W-1:0]  pend_hdl_q;
  logic [RES_W-1:0]     nres_q;
  status_e              st_q;
  logic                 out_valid_q;
  status_e              out_st_q;
  logic [HANDLE_W-1:0]  out_hdl_q;
  logic                 out_last_q;

  logic                 cur_valid;
  logic [HANDLE_W-1:0]  cur_hdl;
  logic [TICK_BITS-1:0] cur_diff;
  logic                 idx_last;
  logic                 out_space;

  assign cur_valid = slot_valid_q[idx_q];
  assign cur_hdl   = slot_handle_q[idx_q];
  assign cur_diff  = now_q - slot_dl_q[idx_q];
  assign idx_last  = (idx_q == IDX_W'(SLOT_COUNT - 1));
  assign out_space = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.dur_zero   = dur_zero_q;
    stat_o.full       = (active_q >= CNT_W'(SLOT_COUNT));
    stat_o.empty      = (active_q == '0);
    stat_o.cur_valid  = cur_valid;
    stat_o.hit        = cur_valid && (cur_hdl == hdl_q);
    stat_o.due        = cur_valid && !cur_diff[TICK_BITS-1];
    stat_o.idx_last   = idx_last;
    stat_o.free_found = free_found_q;
    stat_o.pend       = pend_q;
    stat_o.out_space  = out_space;
    stat_o.cap        = (nres_q == RES_W'(MAX_RESULTS));
  end

  // Latched command fields, reciprocal product, deadline, status and scan notes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= opcode_e'(opcode_i);
      hdl_q      <= handle_i;
      dur_zero_q <= (duration_ms_i == '0);
      prod_q     <= PROD_W'(duration_ms_i) * PROD_W'(DIV_M);
    end
    if (cmd_i.load_dl) begin
      dl_q <= now_q + TICK_BITS'(prod_q[PROD_W-1:DIV_SH]);
    end
    if (cmd_i.set_st) begin
      st_q <= cmd_i.st;
    end
    if (cmd_i.note_free) begin
      free_idx_q <= idx_q;
    end
    if (cmd_i.wr_expire) begin
      pend_hdl_q <= cur_hdl;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_add) begin
      slot_handle_q[free_idx_q] <= hdl_q;
      slot_dl_q[free_idx_q]     <= dl_q;
    end
    if (cmd_i.wr_rearm) begin
      slot_dl_q[idx_q] <= dl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
      active_q <= '0;
      now_q    <= '0;
    end else begin
      if (cmd_i.inc_now) begin
        now_q <= now_q + 1'b1;
      end
      if (cmd_i.wr_add) begin
        slot_valid_q[free_idx_q] <= 1'b1;
        active_q <= active_q + 1'b1;
      end else if (cmd_i.wr_remove || cmd_i.wr_expire) begin
        slot_valid_q[idx_q] <= 1'b0;
        active_q <= active_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      free_found_q <= 1'b0;
      pend_q       <= 1'b0;
      nres_q       <= '0;
    end else begin
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
      end else if (cmd_i.scan_inc) begin
        idx_q <= idx_last ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.load_item) begin
        free_found_q <= 1'b0;
        pend_q       <= 1'b0;
        nres_q       <= '0;
      end else begin
        if (cmd_i.note_free) begin
          free_found_q <= 1'b1;
        end
        if (cmd_i.wr_expire) begin
          pend_q <= 1'b1;
          nres_q <= nres_q + 1'b1;
        end else if (cmd_i.push_pend) begin
          pend_q <= 1'b0;
        end
      end
    end
  end

  // Result register; an expired hit pushes the previously held handle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_res || cmd_i.push_pend || (cmd_i.wr_expire && pend_q)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.push_res) begin
      out_st_q   <= st_q;
      out_hdl_q  <= hdl_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.push_pend) begin
      out_st_q   <= ST_EXPIRED;
      out_hdl_q  <= pend_hdl_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.wr_expire && pend_q) begin
      out_st_q   <= ST_EXPIRED;
      out_hdl_q  <= pend_hdl_q;
      out_last_q <= 1'b0;
    end else begin
      out_st_q   <= out_st_q;
      out_hdl_q  <= out_hdl_q;
      out_last_q <= out_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign out_handle_o = out_hdl_q;
  assign last_o       = out_last_q;

endmodule

/* sv/stst_ctrl.sv */
// Controller state machine of the soft timer slot table.
module stst_ctrl import stst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.op)
          OP_TICK:    state_d = S_IDLE;
          OP_SERVICE: state_d = stat_i.empty ? S_IDLE : S_SCAN;
          OP_START:   state_d = (stat_i.dur_zero || stat_i.full) ? S_RESULT : S_SCAN;
          OP_STOP:    state_d = stat_i.empty ? S_RESULT : S_SCAN;
          default:    state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        unique case (stat_i.op)
          OP_START: begin
            if (stat_i.hit) state_d = S_RESULT;
            else if (stat_i.idx_last) state_d = S_ADD;
          end
          OP_STOP: begin
            if (stat_i.hit || stat_i.idx_last) state_d = S_RESULT;
          end
          OP_SERVICE: begin
            if (stat_i.cap) begin
              state_d = S_FLUSH;
            end else if (!(stat_i.due && stat_i.pend && !stat_i.out_space)
                         && stat_i.idx_last) begin
              state_d = S_FLUSH;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_ADD:    state_d = S_RESULT;
      S_RESULT: begin
        if (stat_i.out_space) state_d = S_IDLE;
      end
      S_FLUSH: begin
        if (!stat_i.pend || stat_i.out_space) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_REJECTED;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_DECODE: begin
        unique case (stat_i.op)
          OP_TICK: cmd_o.inc_now = 1'b1;
          OP_SERVICE: cmd_o.scan_clr = 1'b1;
          OP_START: begin
            if (stat_i.dur_zero || stat_i.full) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_REJECTED;
            end else begin
              cmd_o.load_dl  = 1'b1;
              cmd_o.scan_clr = 1'b1;
            end
          end
          OP_STOP: begin
            if (stat_i.empty) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_REJECTED;
            end else begin
              cmd_o.scan_clr = 1'b1;
            end
          end
          default: cmd_o.scan_clr = 1'b0;
        endcase
      end
      S_SCAN: begin
        unique case (stat_i.op)
          OP_START: begin
            if (stat_i.hit) begin
              cmd_o.wr_rearm = 1'b1;
              cmd_o.set_st   = 1'b1;
              cmd_o.st       = ST_REARMED;
            end else begin
              cmd_o.note_free = !stat_i.cur_valid && !stat_i.free_found;
              cmd_o.scan_inc  = 1'b1;
            end
          end
          OP_STOP: begin
            if (stat_i.hit) begin
              cmd_o.wr_remove = 1'b1;
              cmd_o.set_st    = 1'b1;
              cmd_o.st        = ST_REMOVED;
            end else if (stat_i.idx_last) begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_NOTFOUND;
            end else begin
              cmd_o.scan_inc = 1'b1;
            end
          end
          OP_SERVICE: begin
            if (!stat_i.cap) begin
              if (stat_i.due) begin
                if (!stat_i.pend || stat_i.out_space) begin
                  cmd_o.wr_expire = 1'b1;
                  cmd_o.scan_inc  = 1'b1;
                end
              end else begin
                cmd_o.scan_inc = 1'b1;
              end
            end
          end
          default: cmd_o.scan_inc = 1'b0;
        endcase
      end
      S_ADD: begin
        cmd_o.set_st = 1'b1;
        if (stat_i.free_found) begin
          cmd_o.wr_add = 1'b1;
          cmd_o.st     = ST_ADDED;
        end else begin
          cmd_o.st = ST_REJECTED;
        end
      end
      S_RESULT: begin
        cmd_o.push_res = stat_i.out_space;
      end
      S_FLUSH: begin
        cmd_o.push_pend = stat_i.pend && stat_i.out_space;
      end
      default: cmd_o.push_res = 1'b0;
    endcase
  end

endmodule

/* sv/soft_timer_slot_table.sv */
// Top level of the soft timer slot table: controller, datapath and channel hookup.
//
// The block keeps SLOT_COUNT timer slots, each with a handle and a deadline in
// ticks, next to a tick counter that each tick command advances. One command
// is taken per input transfer and handled to its end before the next is taken.
// A tick advance gives no result. Start and stop walk the slot table at one
// slot per cycle; a start that fills a free slot writes it in an add state, and
// a rejected start or stop goes from decode straight to its result. Service
// also walks every slot once, one per cycle, and sends each expired handle in
// slot order; the last one carries the last flag. The single-entry result
// register lets a command be taken while a result still waits, but the final
// result, and the service walk at an expired slot behind a held handle, stall
// while the output side holds off a transfer. The deadline is now plus the
// duration divided by the tick period, which comes from one registered reciprocal
// multiplication; a deadline counts as reached when now minus deadline is not
// negative as a signed tick-width value, so the counter may wrap freely.
module soft_timer_slot_table import stst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stst_in_if.sink    in_i,
  stst_out_if.source out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller sequences each command; it sees the datapath only through
  // the command and status structures.
  stst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the slot table, the counters and the result register
  // that drives the output channel.
  stst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (in_i.opcode),
    .handle_i      (in_i.handle),
    .duration_ms_i (in_i.duration_ms),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .out_handle_o  (out_o.out_handle),
    .last_o        (out_o.last)
  );

endmodule

/* test/soft_timer_slot_table_tb.sv */
// Testbench for the soft timer slot table: directed and random commands checked by a slot predictor.
`timescale 1ns / 100ps

import stst_pkg::*;

// One result as the output channel carries it.
typedef struct packed {
  status_e             status;
  logic [HANDLE_W-1:0] hnd;
  logic                last;
} timer_result_t;

// Keeps its own copy of the timer slots and the tick counter. Every accepted
// command is played into it and the results it should cause are queued.
// Results leaving the block are compared in order.
class timer_table_sb;
  bit                   armed[SLOT_COUNT];
  logic [HANDLE_W-1:0]  owner[SLOT_COUNT];
  logic [TICK_BITS-1:0] deadline[SLOT_COUNT];
  int unsigned          n_armed   = 0;
  logic [TICK_BITS-1:0] now_ticks = '0;
  timer_result_t        due_q[$];
  int unsigned          n_errors  = 0;

  task report(string msg);
    n_errors++;
    if (n_errors <= 100) $display("%0t ns: %s", $time, msg);
  endtask

  function int unsigned pending();
    return due_q.size();
  endfunction

  function void push(status_e st, logic [HANDLE_W-1:0] h, logic l);
    timer_result_t r;
    r.status = st;
    r.hnd    = h;
    r.last   = l;
    due_q.push_back(r);
  endfunction

  // A deadline is reached when now minus deadline is not negative as a
  // signed tick-width value, so the counter may wrap.
  function bit reached(logic [TICK_BITS-1:0] dl);
    logic [TICK_BITS-1:0] diff;
    diff = now_ticks - dl;
    return !diff[TICK_BITS-1];
  endfunction

  function void note_cmd(opcode_e op, logic [HANDLE_W-1:0] h, logic [DUR_W-1:0] ms);
    int                   free_idx;
    int                   n_due;
    int                   n_sent;
    logic [TICK_BITS-1:0] dl;
    free_idx = -1;
    n_due    = 0;
    n_sent   = 0;
    dl       = now_ticks + TICK_BITS'(ms / TICK_PERIOD_MS);
    case (op)
      OP_TICK: begin
        now_ticks = now_ticks + 1'b1;
      end
      OP_SERVICE: begin
        if (n_armed == 0) return;
        for (int i = 0; i < SLOT_COUNT; i++)
          if (armed[i] && reached(deadline[i]) && n_due < MAX_RESULTS) n_due++;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (armed[i] && reached(deadline[i]) && n_sent < n_due) begin
            armed[i] = 1'b0;
            n_armed--;
            n_sent++;
            push(ST_EXPIRED, owner[i], n_sent == n_due);
          end
        end
      end
      OP_START: begin
        // A full table rejects even a handle that is already armed.
        if (ms == 0 || n_armed >= SLOT_COUNT) begin
          push(ST_REJECTED, h, 1'b1);
          return;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (armed[i]) begin
            if (owner[i] == h) begin
              deadline[i] = dl;
              push(ST_REARMED, h, 1'b1);
              return;
            end
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (free_idx < 0) begin
          push(ST_REJECTED, h, 1'b1);
          return;
        end
        armed[free_idx]    = 1'b1;
        owner[free_idx]    = h;
        deadline[free_idx] = dl;
        n_armed++;
        push(ST_ADDED, h, 1'b1);
      end
      default: begin
        if (n_armed == 0) begin
          push(ST_REJECTED, h, 1'b1);
          return;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (armed[i] && owner[i] == h) begin
            armed[i] = 1'b0;
            n_armed--;
            push(ST_REMOVED, h, 1'b1);
            return;
          end
        end
        push(ST_NOTFOUND, h, 1'b1);
      end
    endcase
  endfunction

  task check_result(logic [2:0] st, logic [HANDLE_W-1:0] h, logic l);
    timer_result_t want;
    if (due_q.size() == 0) begin
      report($sformatf("unexpected result: status %0d handle 0x%02h last %0b", st, h, l));
      return;
    end
    want = due_q.pop_front();
    if (st !== want.status || h !== want.hnd || l !== want.last)
      report($sformatf("result status %0d handle 0x%02h last %0b, predicted %0d 0x%02h %0b",
                       st, h, l, want.status, want.hnd, want.last));
  endtask
endclass

module soft_timer_slot_table_tb;

  // The slowest correct run is far below this: about 160 commands, each with
  // a random sender gap and a slot walk, and up to 16 results that each may
  // sit out a long receiver stall, plus one long hold-off.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int          RANDOM_ITEMS  = 136;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 2 * SLOT_COUNT + 8;

  logic clk_i;
  logic rst_ni;

  stst_in_if  cmd_if ();
  stst_out_if res_if ();

  timer_table_sb tracker = new;

  // Set by the stimulus to ask the receiver for one long stretch of
  // back-pressure; the receiver clears it once it has taken the request.
  bit hold_req;
  // While set, the sender offers commands back to back.
  bit src_quiet;
  int unsigned cycle_cnt;

  soft_timer_slot_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver. Ready changes at the falling edge and transfers are taken at the
  // rising edge. Quiet stretches keep ready high apart from the long hold-off;
  // otherwise a quarter of the draws start a stall, one in a hundred a long one.
  initial begin : result_sink
    int  stall_left;
    int  hold_left;
    int  mode_left;
    int  r;
    bit  quiet;
    bit  go;
    stall_left   = 0;
    hold_left    = 0;
    mode_left    = 150;
    quiet        = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        quiet     = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(100, 300);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        go = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        go = 1'b0;
      end else begin
        r = $urandom_range(0, 999);
        if (quiet || r >= 250) begin
          go = 1'b1;
        end else if (r < 10) begin
          go         = 1'b0;
          stall_left = $urandom_range(15, 60);
        end else begin
          go         = 1'b0;
          stall_left = $urandom_range(0, 2);
        end
      end
      res_if.ready <= go;
      @(posedge clk_i);
      if (res_if.valid && res_if.ready)
        tracker.check_result(res_if.status, res_if.out_handle, res_if.last);
    end
  end

  // Offers one command and returns at the rising edge that completes its
  // transfer. Valid stays high into the next call when no gap follows, so the
  // payload simply changes at the next falling edge.
  task automatic send_cmd(opcode_e op, logic [HANDLE_W-1:0] h, logic [DUR_W-1:0] ms);
    int gap;
    int r;
    gap = 0;
    if (!src_quiet) begin
      r = $urandom_range(0, 99);
      if (r < 55)      gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else             gap = $urandom_range(12, 40);
    end
    repeat (gap) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= op;
    cmd_if.handle      <= h;
    cmd_if.duration_ms <= ms;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    tracker.note_cmd(op, h, ms);
  endtask

  task automatic release_cmd();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
  endtask

  task automatic drain();
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random commands. Most handles come from a small pool so that re-arms,
  // stops that hit, and a full table all happen; short durations expire
  // within 24 ticks, and some durations reach 163840 ms.
  task automatic send_random();
    int                  r;
    opcode_e             op;
    logic [HANDLE_W-1:0] h;
    logic [DUR_W-1:0]    ms;
    r = $urandom_range(0, 99);
    if (r < 28)      op = OP_TICK;
    else if (r < 43) op = OP_SERVICE;
    else if (r < 77) op = OP_START;
    else             op = OP_STOP;
    if ($urandom_range(0, 99) < 85) h = HANDLE_W'($urandom_range(0, 23));
    else                            h = HANDLE_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 4)       ms = '0;
    else if (r < 60) ms = DUR_W'($urandom_range(1, 120));
    else if (r < 85) ms = DUR_W'($urandom_range(121, 3000));
    else             ms = DUR_W'($urandom_range(0, 163840));
    send_cmd(op, h, ms);
  endtask

  initial begin : stimulus
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.opcode      = OP_TICK;
    cmd_if.handle      = '0;
    cmd_if.duration_ms = '0;
    hold_req           = 1'b0;
    src_quiet          = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table: stop is rejected and service stays silent.
    send_cmd(OP_STOP, 8'h3C, '0);
    send_cmd(OP_SERVICE, '0, '0);
    // Zero duration is rejected.
    send_cmd(OP_START, 8'h00, '0);
    // A long timeout, then a re-arm of the same handle that is due at once
    // because a duration under one tick period adds nothing to now.
    send_cmd(OP_START, 8'hFF, DUR_W'(163840));
    send_cmd(OP_START, 8'hFF, DUR_W'(4));
    // Stop with a handle that no slot holds.
    send_cmd(OP_STOP, 8'hA5, DUR_W'(131071));
    // Fill the remaining slots; every deadline equals now.
    for (int i = 0; i < SLOT_COUNT - 1; i++)
      send_cmd(OP_START, HANDLE_W'(i * 17), DUR_W'(1 + i % 4));
    // Full table: a known handle and a new one are both rejected.
    send_cmd(OP_START, 8'hFF, DUR_W'(50));
    send_cmd(OP_START, 8'h80, DUR_W'(50));
    send_cmd(OP_STOP, 8'hEE, '0);
    // Everything left is due: one service reports the whole table in slot order.
    send_cmd(OP_SERVICE, '0, '0);

    // The receiver holds off while the first random commands stream in back
    // to back, so the block has to stall its input.
    hold_req = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // The sender stops until every predicted result has come out.
        release_cmd();
        drain();
      end
      if (i % 32 == 0) src_quiet = (i == 0) || ($urandom_range(0, 3) == 0);
      send_random();
    end
    release_cmd();
    drain();
    // Leave room for a stray result after the last predicted one.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
